### rtl/core/usoa_pkg.sv
`default_nettype none

package usoa_pkg;

  // Q16.16 word as seen on the field and energy ports
  typedef logic signed [31:0] q16_t;

  // Q1.15 vector component
  typedef logic signed [15:0] q15_t;

  // Per-item data that rides along the pipeline next to the math
  typedef struct packed {
    q15_t axis_x;
    q15_t axis_y;
    q15_t axis_z;
    q16_t kc;
    q16_t field_x;
    q16_t field_y;
    q16_t field_z;
  } usoa_carry_t;

  // Pipeline depth from input transfer to output register
  localparam int unsigned LATENCY = 12;

  // Widths of the power terms (all Q.24, |d| <= 3)
  localparam int unsigned D1_W = 27;
  localparam int unsigned D2_W = 29;
  localparam int unsigned D3_W = 30;
  localparam int unsigned D4_W = 32;
  localparam int unsigned D5_W = 33;
  localparam int unsigned D6_W = 35;

  // Polynomial accumulators, Q.24
  localparam int unsigned POLY_W = 45;

  // Wide field coefficient k, Q16.16
  localparam int unsigned KF_W = 48;

  // Polynomial coefficients
  localparam logic signed [POLY_W-1:0] C_F5 = 45'sd1386;
  localparam logic signed [POLY_W-1:0] C_F3 = 45'sd1260;
  localparam logic signed [POLY_W-1:0] C_F1 = 45'sd210;
  localparam logic signed [POLY_W-1:0] C_E6 = 45'sd231;
  localparam logic signed [POLY_W-1:0] C_E4 = 45'sd315;
  localparam logic signed [POLY_W-1:0] C_E2 = 45'sd105;

  // Divide by 24*256 = 3 * 2^11: half of the divisor, then floor(a/3) by reciprocal
  localparam logic [POLY_W-1:0] DIV_HALF   = 45'd3072;
  localparam logic [31:0]       RECIP3     = 32'hAAAA_AAAB;
  localparam int unsigned       RECIP3_SH  = 33;

  // Arithmetic shift right with round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned sh);
    logic signed [63:0] half;
    logic signed [63:0] bias;
    half = $signed(64'd1 << (sh - 1));
    bias = half - $signed({63'd0, v[63]});
    return (v + bias) >>> sh;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic q16_t sat32(input logic signed [63:0] v);
    logic signed [63:0] vmax;
    logic signed [63:0] vmin;
    vmax = 64'sd2147483647;
    vmin = -64'sd2147483648;
    if (v > vmax) begin
      return 32'sh7FFF_FFFF;
    end else if (v < vmin) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/uniaxial_sixth_order_anisotropy_top.sv
// Sixth-order uniaxial anisotropy field and energy, one atom per transfer.
//
// Input channel: in_valid / in_stall carry the spin, easy axis, anisotropy
// constant K and incoming field. Output channel: out_valid / out_stall carry
// the updated field and the energy. One result leaves for every input.
// The enable register is written through cfg_we / cfg_wdata; with enable
// clear the field passes through and the energy is still produced.
//
// Throughput is one item per cycle while out_stall does not hold a valid
// output; the twelve-stage pipeline runs the dot product, the power chain
// d..d^6, the divide by 3 * 2^11 with a reciprocal, the K and axis products.
// When the receiver stalls a valid output, the whole pipeline holds and
// in_stall is raised in the same cycle; bubbles are carried, not collapsed.
// Synchronous reset clears all valid bits and the enable register; no
// results are in flight after reset and payload registers are not cleared.
`default_nettype none

module uniaxial_sixth_order_anisotropy_top (
  input  wire logic           clk,
  input  wire logic           rst,
  // configuration
  input  wire logic           cfg_we,
  input  wire logic           cfg_wdata,
  // input channel
  input  wire logic           in_valid,
  output logic                in_stall,
  input  usoa_pkg::q15_t      spin_x,
  input  usoa_pkg::q15_t      spin_y,
  input  usoa_pkg::q15_t      spin_z,
  input  usoa_pkg::q15_t      axis_x,
  input  usoa_pkg::q15_t      axis_y,
  input  usoa_pkg::q15_t      axis_z,
  input  usoa_pkg::q16_t      anisotropy_constant,
  input  usoa_pkg::q16_t      field_in_x,
  input  usoa_pkg::q16_t      field_in_y,
  input  usoa_pkg::q16_t      field_in_z,
  // output channel
  output logic                out_valid,
  input  wire logic           out_stall,
  output usoa_pkg::q16_t      field_out_x,
  output usoa_pkg::q16_t      field_out_y,
  output usoa_pkg::q16_t      field_out_z,
  output usoa_pkg::q16_t      energy
);

  import usoa_pkg::*;

  localparam int unsigned NCARRY = LATENCY - 1;

  logic              enable;
  logic              adv;
  logic [NCARRY:1]   vld;
  usoa_carry_t       carry [1:NCARRY];

  // stage registers
  logic signed [31:0]       px_1, py_1, pz_1;
  logic signed [D1_W-1:0]   d_2;
  logic signed [D1_W-1:0]   d_3;
  logic signed [D2_W-1:0]   d2_3;
  logic signed [D1_W-1:0]   d_4;
  logic signed [D2_W-1:0]   d2_4;
  logic signed [D3_W-1:0]   d3_4;
  logic signed [D4_W-1:0]   d4_4;
  logic signed [D1_W-1:0]   d_5;
  logic signed [D2_W-1:0]   d2_5;
  logic signed [D3_W-1:0]   d3_5;
  logic signed [D4_W-1:0]   d4_5;
  logic signed [D5_W-1:0]   d5_5;
  logic signed [D6_W-1:0]   d6_5;
  logic signed [POLY_W-1:0] pf_6, pe_6;
  logic [31:0]              af_7, ae_7;
  logic                     nf_7, ne_7;
  q16_t                     qf_8, qe_8;
  logic signed [63:0]       kpf_9, kpe_9;
  logic signed [KF_W-1:0]   kf_10;
  q16_t                     en_10;
  logic signed [63:0]       prx_11, pry_11, prz_11;
  q16_t                     en_11;

  // combinational terms
  logic signed [32:0]       dot_w;
  logic signed [63:0]       sq_w, p3_w, p4_w, p5_w, p6_w;
  logic signed [POLY_W-1:0] pf_w, pe_w;
  logic signed [POLY_W-1:0] absf_w, abse_w;
  logic [POLY_W-1:0]        sumf_w, sume_w;
  logic [63:0]              mf_w, me_w;
  q16_t                     qf_w, qe_w;
  logic signed [63:0]       kf_w, en_w;
  logic signed [63:0]       sx_w, sy_w, sz_w;

  // the whole pipeline moves unless a finished result is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_we) begin
      enable <= cfg_wdata;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[NCARRY-1:1], in_valid};
      out_valid <= vld[NCARRY];
    end
  end

  // side data shift line
  always_ff @(posedge clk) begin
    if (adv) begin
      carry[1] <= '{axis_x: axis_x, axis_y: axis_y, axis_z: axis_z,
                    kc: anisotropy_constant,
                    field_x: field_in_x, field_y: field_in_y, field_z: field_in_z};
      for (int k = 2; k <= NCARRY; k++) begin
        carry[k] <= carry[k-1];
      end
    end
  end

  // stage 1: component products, Q.30
  always_ff @(posedge clk) begin
    if (adv) begin
      px_1 <= 32'(spin_x) * 32'(axis_x);
      py_1 <= 32'(spin_y) * 32'(axis_y);
      pz_1 <= 32'(spin_z) * 32'(axis_z);
    end
  end

  // stage 2: dot product rounded to Q.24
  assign dot_w = 33'(px_1) + 33'(py_1) + 33'(pz_1);

  always_ff @(posedge clk) begin
    if (adv) begin
      d_2 <= D1_W'(rnd_shr(64'(dot_w), 6));
    end
  end

  // stage 3: d^2
  assign sq_w = 64'(d_2) * 64'(d_2);

  always_ff @(posedge clk) begin
    if (adv) begin
      d_3  <= d_2;
      d2_3 <= D2_W'(rnd_shr(sq_w, 24));
    end
  end

  // stage 4: d^3 and d^4
  assign p3_w = 64'(d2_3) * 64'(d_3);
  assign p4_w = 64'(d2_3) * 64'(d2_3);

  always_ff @(posedge clk) begin
    if (adv) begin
      d_4  <= d_3;
      d2_4 <= d2_3;
      d3_4 <= D3_W'(rnd_shr(p3_w, 24));
      d4_4 <= D4_W'(rnd_shr(p4_w, 24));
    end
  end

  // stage 5: d^5 and d^6
  assign p5_w = 64'(d4_4) * 64'(d_4);
  assign p6_w = 64'(d4_4) * 64'(d2_4);

  always_ff @(posedge clk) begin
    if (adv) begin
      d_5  <= d_4;
      d2_5 <= d2_4;
      d3_5 <= d3_4;
      d4_5 <= d4_4;
      d5_5 <= D5_W'(rnd_shr(p5_w, 24));
      d6_5 <= D6_W'(rnd_shr(p6_w, 24));
    end
  end

  // stage 6: field and energy polynomials, constant coefficients
  assign pf_w = POLY_W'(d5_5) * C_F5 - POLY_W'(d3_5) * C_F3 + POLY_W'(d_5) * C_F1;
  assign pe_w = POLY_W'(d6_5) * C_E6 - POLY_W'(d4_5) * C_E4 + POLY_W'(d2_5) * C_E2;

  always_ff @(posedge clk) begin
    if (adv) begin
      pf_6 <= pf_w;
      pe_6 <= pe_w;
    end
  end

  // stage 7: magnitude, add half divisor, divide by 2^11
  assign absf_w = pf_6[POLY_W-1] ? -pf_6 : pf_6;
  assign abse_w = pe_6[POLY_W-1] ? -pe_6 : pe_6;
  assign sumf_w = $unsigned(absf_w) + DIV_HALF;
  assign sume_w = $unsigned(abse_w) + DIV_HALF;

  always_ff @(posedge clk) begin
    if (adv) begin
      af_7 <= sumf_w[42:11];
      ae_7 <= sume_w[42:11];
      nf_7 <= pf_6[POLY_W-1];
      ne_7 <= pe_6[POLY_W-1];
    end
  end

  // stage 8: divide by 3 through the reciprocal, restore sign
  assign mf_w = {32'd0, af_7} * {32'd0, RECIP3};
  assign me_w = {32'd0, ae_7} * {32'd0, RECIP3};
  assign qf_w = nf_7 ? -$signed({1'b0, mf_w[63:RECIP3_SH]})
                     :  $signed({1'b0, mf_w[63:RECIP3_SH]});
  assign qe_w = ne_7 ? -$signed({1'b0, me_w[63:RECIP3_SH]})
                     :  $signed({1'b0, me_w[63:RECIP3_SH]});

  always_ff @(posedge clk) begin
    if (adv) begin
      qf_8 <= qf_w;
      qe_8 <= qe_w;
    end
  end

  // stage 9: scale by K
  always_ff @(posedge clk) begin
    if (adv) begin
      kpf_9 <= 64'(carry[8].kc) * 64'(qf_8);
      kpe_9 <= 64'(carry[8].kc) * 64'(qe_8);
    end
  end

  // stage 10: round k to Q16.16 (kept wide), negate and clamp energy
  assign kf_w = rnd_shr(kpf_9, 16);
  assign en_w = -rnd_shr(kpe_9, 16);

  always_ff @(posedge clk) begin
    if (adv) begin
      kf_10 <= KF_W'(kf_w);
      en_10 <= sat32(en_w);
    end
  end

  // stage 11: k times each axis component
  always_ff @(posedge clk) begin
    if (adv) begin
      prx_11 <= 64'(kf_10) * 64'(carry[10].axis_x);
      pry_11 <= 64'(kf_10) * 64'(carry[10].axis_y);
      prz_11 <= 64'(kf_10) * 64'(carry[10].axis_z);
      en_11  <= en_10;
    end
  end

  // stage 12: round, add to the incoming field, clamp
  assign sx_w = 64'(carry[11].field_x) + rnd_shr(prx_11, 15);
  assign sy_w = 64'(carry[11].field_y) + rnd_shr(pry_11, 15);
  assign sz_w = 64'(carry[11].field_z) + rnd_shr(prz_11, 15);

  always_ff @(posedge clk) begin
    if (adv) begin
      field_out_x <= enable ? sat32(sx_w) : carry[11].field_x;
      field_out_y <= enable ? sat32(sy_w) : carry[11].field_y;
      field_out_z <= enable ? sat32(sz_w) : carry[11].field_z;
      energy      <= en_11;
    end
  end

endmodule

`default_nettype wire

### rtl/core/usoa_checker.sv
`default_nettype none

module usoa_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input usoa_pkg::q16_t      field_out_x,
  input usoa_pkg::q16_t      field_out_y,
  input usoa_pkg::q16_t      field_out_z,
  input usoa_pkg::q16_t      energy
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(field_out_x) &&
      $stable(field_out_y) && $stable(field_out_z) && $stable(energy))
    else $error("output payload changed while stalled");

  // input is held off exactly when a finished result is waiting
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the output hold");

  // nothing is in flight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // a valid result carries no unknown bits
  a_out_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown({field_out_x, field_out_y, field_out_z, energy}))
    else $error("unknown bits in a valid result");

endmodule

bind uniaxial_sixth_order_anisotropy_top usoa_checker u_usoa_checker (.*);

`default_nettype wire
